/* design/bounded_deque_assert.svh */
// Assertion macros for the bounded deque RTL.
// Needs nothing else; included by bdq_datapath, the file that carries assertions.
`ifndef BOUNDED_DEQUE_ASSERT_SVH
`define BOUNDED_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BDQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bounded_deque assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bounded_deque assertion failed");

`endif

/* design/bdq_pkg.sv */
// Package for the bounded deque: sizes, request codes, payload structs,
// controller states and the command struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int POS_W    = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IO_DATA_W = 32;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type              req_type;
        logic [IO_DATA_W-1:0]   data_in;
        logic [POS_W-1:0]       position;
    } t_req;

    typedef struct packed {
        logic [IO_DATA_W-1:0]   data_out;
        logic                   found;
        logic                   dropped;
        logic [OUT_CNT_W-1:0]   entry_count;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // run the item against the ring
    } t_cmd;

endpackage

`default_nettype wire

/* design/bdq_ctrl.sv */
// Controller for the bounded deque: accept / execute / result sequencer.
// Uses bdq_pkg for the state enum and command struct.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    output logic            o_valid,
    output bdq_pkg::t_cmd   o_cmd
);

    bdq_pkg::t_state r_state;
    bdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            bdq_pkg::ST_IDLE: begin
                n_state = start ? bdq_pkg::ST_EXEC : bdq_pkg::ST_IDLE;
            end
            bdq_pkg::ST_EXEC: begin
                n_state = bdq_pkg::ST_DONE;
            end
            bdq_pkg::ST_DONE: begin
                n_state = start ? bdq_pkg::ST_EXEC : bdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy      = (r_state == bdq_pkg::ST_EXEC);
        o_valid   = (r_state == bdq_pkg::ST_DONE);
        o_cmd.load = start && (r_state != bdq_pkg::ST_EXEC);
        o_cmd.exec = (r_state == bdq_pkg::ST_EXEC);
    end

endmodule

`default_nettype wire

/* design/bdq_datapath.sv */
// Datapath for the bounded deque: request latch, head/count registers,
// ring memory with registered read, result flags. Uses bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_deque_assert.svh"

module bdq_datapath (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire bdq_pkg::t_cmd i_cmd,
    input  wire bdq_pkg::t_req i_req,
    output bdq_pkg::t_rsp   o_rsp
);

    localparam int SUM_W = bdq_pkg::CNT_W + 1;

    // head + offset modulo DEPTH; both operands are below DEPTH
    function automatic logic [bdq_pkg::SLOT_W-1:0] slot_add(
        input logic [bdq_pkg::SLOT_W-1:0] head,
        input logic [bdq_pkg::CNT_W-1:0]  ofs
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(ofs);
        if (sum >= SUM_W'(bdq_pkg::DEPTH)) begin
            sum = sum - SUM_W'(bdq_pkg::DEPTH);
        end
        return bdq_pkg::SLOT_W'(sum);
    endfunction

    logic [bdq_pkg::DATA_WIDTH-1:0] r_mem [bdq_pkg::DEPTH];

    bdq_pkg::t_req                  r_req;
    logic [bdq_pkg::SLOT_W-1:0]     r_head;
    logic [bdq_pkg::SLOT_W-1:0]     n_head;
    logic [bdq_pkg::CNT_W-1:0]      r_count;
    logic [bdq_pkg::CNT_W-1:0]      n_count;
    logic                           r_found;
    logic                           n_found;
    logic                           r_dropped;
    logic                           n_dropped;
    logic [bdq_pkg::DATA_WIDTH-1:0] r_rd_data;

    logic                           wr_en;
    logic [bdq_pkg::SLOT_W-1:0]     wr_addr;
    logic [bdq_pkg::SLOT_W-1:0]     rd_addr;
    logic                           full;
    logic                           empty;
    logic [bdq_pkg::CMP_W-1:0]      pos_ext;
    logic [bdq_pkg::CMP_W-1:0]      cnt_ext;

    always_comb begin
        full    = (r_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
        empty   = (r_count == '0);
        pos_ext = bdq_pkg::CMP_W'(r_req.position);
        cnt_ext = bdq_pkg::CMP_W'(r_count);

        n_head    = r_head;
        n_count   = r_count;
        n_found   = 1'b0;
        n_dropped = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_head;
        rd_addr   = r_head;

        unique case (r_req.req_type)
            bdq_pkg::REQ_APPEND: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = slot_add(r_head, r_count);
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::REQ_PUSH: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_head  = (r_head == '0) ? bdq_pkg::SLOT_W'(bdq_pkg::DEPTH - 1)
                                             : r_head - bdq_pkg::SLOT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::REQ_REMOVE: begin
                if (!empty) begin
                    n_found = 1'b1;
                    rd_addr = r_head;
                    n_head  = slot_add(r_head, bdq_pkg::CNT_W'(1));
                    n_count = r_count - bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::REQ_READ: begin
                if (pos_ext < cnt_ext) begin
                    n_found = 1'b1;
                    rd_addr = slot_add(r_head, bdq_pkg::CNT_W'(pos_ext));
                end
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_found   <= 1'b0;
            r_dropped <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_found   <= n_found;
            r_dropped <= n_dropped;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= bdq_pkg::DATA_WIDTH'(r_req.data_in);
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        o_rsp.data_out    = r_found ? bdq_pkg::IO_DATA_W'(r_rd_data) : '0;
        o_rsp.found       = r_found;
        o_rsp.dropped     = r_dropped;
        o_rsp.entry_count = bdq_pkg::OUT_CNT_W'(r_count);
    end

    `BDQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    `BDQ_ASSERT_NOW(a_found_not_dropped, i_clk, i_rst_n, r_found, !r_dropped)
    `BDQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        i_cmd.exec && !full && (r_req.req_type == bdq_pkg::REQ_APPEND ||
        r_req.req_type == bdq_pkg::REQ_PUSH),
        r_count == $past(r_count) + bdq_pkg::CNT_W'(1))
    `BDQ_ASSERT_NEXT(a_empty_remove_holds, i_clk, i_rst_n,
        i_cmd.exec && empty && r_req.req_type == bdq_pkg::REQ_REMOVE,
        !r_found && $stable(r_head) && $stable(r_count))

endmodule

`default_nettype wire

/* design/bounded_deque.sv */
// Top level of the bounded deque: controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of DEPTH words held in a ring memory.
//
// Request channel: drive i_req and raise start; the item is taken at the
// rising edge where start is high and busy is low. req_type picks append at
// back, push at front, remove front, or read at position (non-destructive).
//
// Result channel: o_valid pulses for one cycle with o_rsp. The receiver
// cannot hold it off, so it must take the item in that cycle.
//   found    - remove/read returned an entry (data_out is zero otherwise)
//   dropped  - append/push refused because the ring was full
//   entry_count - entries held after the request
//
// Timing: the accept edge loads the item, the execute state does the ring
// write or registered ring read plus head/count update, and the result
// state then raises o_valid. busy is high in the execute state, so no new
// item is taken then; a new item may be accepted during the result cycle.
//
// Reset (i_rst_n low, synchronous) empties the queue: head and count go to
// zero. Ring contents are not cleared; only held slots are ever read.
module bounded_deque (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire bdq_pkg::t_req i_req,
    output logic            busy,
    output logic            o_valid,
    output bdq_pkg::t_rsp   o_rsp
);

    bdq_pkg::t_cmd cmd;

    // sequencer: load on accept, execute next cycle, strobe result after
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // ring memory, head pointer, count and result registers
    bdq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

/* verif/bdq_checker.sv */
// Result checker for the bounded deque: predicts each result from accepted items.
// Depends on bdq_pkg; watches the request and result ports of bounded_deque.
`timescale 1ns / 1ps

module bdq_checker
    import bdq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire logic   i_busy,
    input  t_req        i_req,
    input  wire logic   i_valid,
    input  t_rsp        i_rsp,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow deque state
    logic [DATA_WIDTH-1:0] ring [DEPTH];
    int   head_slot = 0;
    int   held      = 0;
    t_rsp results_owed[$];
    int   fails     = 0;

    assign o_fail_count = fails;

    function automatic int slot_of(int offset);
        int s;
        s = head_slot + offset;
        if (s >= DEPTH) s -= DEPTH;
        return s;
    endfunction

    // Applies one item to the shadow deque, returns the result it owes
    function automatic t_rsp deque_apply(t_req r);
        t_rsp                  rsp;
        logic [DATA_WIDTH-1:0] val;
        rsp = '0;
        val = '0;
        case (r.req_type)
            REQ_APPEND, REQ_PUSH: begin
                if (held >= DEPTH) begin
                    rsp.dropped = 1'b1;
                end else if (r.req_type == REQ_APPEND) begin
                    ring[slot_of(held)] = DATA_WIDTH'(r.data_in);
                    held++;
                end else begin
                    head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                    ring[head_slot] = DATA_WIDTH'(r.data_in);
                    held++;
                end
            end
            REQ_REMOVE: begin
                if (held != 0) begin
                    val       = ring[head_slot];
                    rsp.found = 1'b1;
                    head_slot = slot_of(1);
                    held--;
                end
            end
            default: begin
                if (int'(r.position) < held) begin
                    val       = ring[slot_of(int'(r.position))];
                    rsp.found = 1'b1;
                end
            end
        endcase
        rsp.data_out    = IO_DATA_W'(val);
        rsp.entry_count = OUT_CNT_W'(held);
        return rsp;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            head_slot = 0;
            held      = 0;
            results_owed.delete();
        end else begin
            if (i_start && !i_busy) results_owed.push_back(deque_apply(i_req));
            if (i_valid) begin
                if (results_owed.size() == 0) begin
                    $error("result with nothing outstanding: %p", i_rsp);
                    fails++;
                end else begin
                    want = results_owed.pop_front();
                    if (i_rsp.data_out !== want.data_out) begin
                        $error("data_out: expected %h, got %h", want.data_out, i_rsp.data_out);
                        fails++;
                    end
                    if (i_rsp.found !== want.found) begin
                        $error("found: expected %b, got %b", want.found, i_rsp.found);
                        fails++;
                    end
                    if (i_rsp.dropped !== want.dropped) begin
                        $error("dropped: expected %b, got %b", want.dropped, i_rsp.dropped);
                        fails++;
                    end
                    if (i_rsp.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_rsp.entry_count);
                        fails++;
                    end
                end
            end
        end
        o_pending <= results_owed.size();
    end

endmodule

/* verif/bounded_deque_tb.sv */
// Testbench top for bounded_deque: clock, reset, item stimulus and verdict.
// Depends on bdq_pkg, bounded_deque and bdq_checker.
`timescale 1ns / 1ps

module bounded_deque_tb;
    import bdq_pkg::*;

    // Quiet cycles (nothing taken, no result) before the run is declared hung.
    // Real gaps come from the result latency plus random sender idling.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 256;
    localparam int BIAS_RUN       = 32;     // items between bias changes

    typedef enum int {
        BIAS_FILL,
        BIAS_DRAIN,
        BIAS_MIXED
    } t_bias;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_valid;
    t_rsp  o_rsp;

    int    fail_count;
    int    pending;
    int    idle_pct     = 0;
    int    quiet_cycles = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bounded_deque DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    bdq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: any item taken or result seen resets the quiet count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
            $display("bounded_deque: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req make_req(t_req_type kind, logic [31:0] word, logic [3:0] pos);
        t_req r;
        r.req_type = kind;
        r.data_in  = word;
        r.position = pos;
        return r;
    endfunction

    // Random item, weighted so the deque swings between full and empty.
    // Roughly one word in eight is all-zeros or all-ones.
    function automatic t_req random_req(t_bias bias);
        int   roll;
        int   lim_app;
        int   lim_push;
        int   lim_rem;
        t_req r;
        case (bias)
            BIAS_FILL:  begin lim_app = 40; lim_push = 70; lim_rem = 85; end
            BIAS_DRAIN: begin lim_app = 15; lim_push = 25; lim_rem = 70; end
            default:    begin lim_app = 25; lim_push = 50; lim_rem = 75; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < lim_app)       r.req_type = REQ_APPEND;
        else if (roll < lim_push) r.req_type = REQ_PUSH;
        else if (roll < lim_rem)  r.req_type = REQ_REMOVE;
        else                      r.req_type = REQ_READ;
        if ($urandom_range(0, 7) == 0)
            r.data_in = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
            r.data_in = $urandom();
        r.position = 4'($urandom_range(0, 15));
        return r;
    endfunction

    // Offers one item and returns at the edge that takes it. Called at a
    // rising edge; start is assigned once per step. Idle gaps, when drawn,
    // wait on a clock edge so the low and the next high never share a step.
    task automatic issue(t_req r);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Sender holds off until every owed result is back. pending is
    // registered, so the loop waits on a clock edge before checking it.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int    phase_idle [4];
        t_bias bias;
        phase_idle = '{0, 69, 0, 26};
        bias       = BIAS_MIXED;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-queue corner cases first
        issue(make_req(REQ_REMOVE, 32'h1234_5678, 4'd0));
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd0));
        issue(make_req(REQ_READ,   32'hFFFF_FFFF, 4'd15));
        // Field extremes; push from head 0 wraps the head to the top slot
        issue(make_req(REQ_APPEND, 32'h0000_0000, 4'd15));
        issue(make_req(REQ_APPEND, 32'hFFFF_FFFF, 4'd0));
        issue(make_req(REQ_PUSH,   32'h8000_0001, 4'd0));
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd0));
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd2));
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd3));   // one past count
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd15));  // far past count
        issue(make_req(REQ_REMOVE, 32'h0000_0000, 4'd0));   // head wraps back
        // Fill to capacity, alternating ends
        for (int k = 0; k < 14; k++) begin
            issue(make_req(k[0] ? REQ_PUSH : REQ_APPEND,
                           k[1] ? 32'h5555_5555 ^ k : 32'hAAAA_AAAA ^ k, 4'(k)));
        end
        // Full: both inserts refused; last slot readable
        issue(make_req(REQ_APPEND, 32'hDEAD_BEEF, 4'd0));
        issue(make_req(REQ_PUSH,   32'hCAFE_F00D, 4'd0));
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd15));
        issue(make_req(REQ_READ,   32'h0000_0000, 4'd0));
        drain();

        // Random phases with different sender idling; the deque is never
        // reset, so contents and head position carry across phases
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % BIAS_RUN == 0) bias = t_bias'($urandom_range(0, 2));
                issue(random_req(bias));
            end
            drain();
        end

        // Idle edges after the last drain catch any stray strobe
        repeat (8) @(posedge i_clk);
        if (pending != 0) $error("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_deque: match");
        end else begin
            $display("bounded_deque: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/bdq_pkg.sv
design/bdq_ctrl.sv
design/bdq_datapath.sv
design/bounded_deque.sv
verif/bdq_checker.sv
verif/bounded_deque_tb.sv
